/* sv/shkfd_pkg.sv */
// ----------------------------------------------------------------------------
// shkfd_pkg - serial HID key frame decoder package
// Shared constants, report patterns, item and register types.
// ----------------------------------------------------------------------------
package shkfd_pkg;

   localparam int REPORT_BYTES      = 8;
   localparam int TIME_BITS_DEFAULT = 32;
   localparam int COUNT_BITS        = 4;
   localparam int STORE_BITS        = 3;
   localparam int PATTERN_COUNT     = 8;
   localparam int CSR_ADDR_BITS     = 4;
   localparam int CSR_DATA_BITS     = 32;
   localparam int LIMIT_BITS        = 16;

   localparam logic [COUNT_BITS-1:0] FRAME_FIRST_DATA = 4'd3;
   localparam logic [COUNT_BITS-1:0] FRAME_LAST       = 4'd10;
   localparam logic [COUNT_BITS-1:0] POS_HDR0         = 4'd0;
   localparam logic [COUNT_BITS-1:0] POS_HDR1         = 4'd1;
   localparam logic [COUNT_BITS-1:0] POS_TYPE         = 4'd2;

   localparam logic [7:0] HDR0     = 8'h57;
   localparam logic [7:0] HDR1     = 8'hAB;
   localparam logic [7:0] HDR_TYPE = 8'h01;

   localparam logic [LIMIT_BITS-1:0] BYTE_GAP_RESET     = 16'd100;
   localparam logic [LIMIT_BITS-1:0] DOUBLE_PRESS_RESET = 16'd500;

   typedef logic [7:0]                rpt_byte_type;
   typedef logic [REPORT_BYTES*8-1:0] report_type;

   typedef enum logic [2:0] {
      KEY_UP          = 3'd0,
      KEY_DOWN        = 3'd1,
      KEY_LEFT        = 3'd2,
      KEY_RIGHT       = 3'd3,
      KEY_ENTER       = 3'd4,
      KEY_DOUBLE_CTRL = 3'd5
   } key_event_type;

   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_CTRL = 2'd1,
      CLS_KEY  = 2'd2
   } rpt_class_type;

   typedef struct packed {
      rpt_class_type cls;
      key_event_type key;
   } rpt_item_type;

   typedef enum logic [1:0] {
      CSR_BYTE_GAP     = 2'd0,
      CSR_DOUBLE_PRESS = 2'd1,
      CSR_KEYBOARD_ID  = 2'd2
   } csr_index_type;

   // byte i of a report sits at bits [8i+7:8i]
   localparam report_type PATTERNS [PATTERN_COUNT] = '{
      64'h0000_0000_0000_0001,
      64'h0000_0000_0000_0010,
      64'h0000_0000_0052_0000,
      64'h0000_0000_0051_0000,
      64'h0000_0000_0050_0000,
      64'h0000_0000_004F_0000,
      64'h0000_0000_0028_0000,
      64'h0000_0000_0058_0000
   };

   localparam rpt_class_type PATTERN_CLASS [PATTERN_COUNT] = '{
      CLS_CTRL, CLS_CTRL, CLS_KEY, CLS_KEY, CLS_KEY, CLS_KEY, CLS_KEY, CLS_KEY
   };

   localparam key_event_type PATTERN_KEY [PATTERN_COUNT] = '{
      KEY_UP, KEY_UP, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT, KEY_ENTER, KEY_ENTER
   };

   // Compare a full report with every fixed pattern in parallel.
   function automatic rpt_item_type classify(input report_type rpt);
      rpt_item_type item;
      item.cls = CLS_NONE;
      item.key = KEY_UP;
      for (int k = PATTERN_COUNT - 1; k >= 0; k--) begin
         if (rpt == PATTERNS[k]) begin
            item.cls = PATTERN_CLASS[k];
            item.key = PATTERN_KEY[k];
         end
      end
      return item;
   endfunction

endpackage

/* sv/shkfd_front.sv */
// ----------------------------------------------------------------------------
// shkfd_front - frame assembly front end
// Accepts bytes, applies the byte-gap restart, checks the header and
// classifies each complete report into a queue item.
// ----------------------------------------------------------------------------
module shkfd_front #(
   parameter int TIME_BITS = shkfd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_rx_byte,
   input  logic [TIME_BITS-1:0]                now_t,
   input  logic [shkfd_pkg::LIMIT_BITS-1:0]    byte_gap,
   input  logic                                q_full,
   output logic                                q_push,
   output shkfd_pkg::rpt_item_type             q_item,
   output logic [TIME_BITS-1:0]                q_time
);

   localparam int STORE_DEPTH = shkfd_pkg::REPORT_BYTES - 1;

   logic [TIME_BITS-1:0]                last_time_ff, last_time_in;
   logic [shkfd_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   shkfd_pkg::rpt_byte_type             report_ff [STORE_DEPTH];

   logic                                accept;
   logic [TIME_BITS-1:0]                elapsed;
   logic                                gap_passed;
   logic [shkfd_pkg::COUNT_BITS-1:0]    pos;
   logic [shkfd_pkg::STORE_BITS-1:0]    store_idx;
   logic                                store_wr;
   shkfd_pkg::report_type               rpt;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign elapsed    = now_t - last_time_ff;
   assign gap_passed = elapsed > TIME_BITS'(byte_gap);
   assign store_idx  = shkfd_pkg::STORE_BITS'(pos - shkfd_pkg::FRAME_FIRST_DATA);

   always_comb begin
      if (count_ff > shkfd_pkg::FRAME_LAST || gap_passed) begin
         pos = '0;
      end else begin
         pos = count_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      last_time_in = last_time_ff;
      store_wr     = 1'b0;
      if (accept) begin
         last_time_in = now_t;
         count_in     = pos + 1'b1;
         case (pos)
            shkfd_pkg::POS_HDR0: begin
               if (req_rx_byte != shkfd_pkg::HDR0) count_in = '0;
            end
            shkfd_pkg::POS_HDR1: begin
               if (req_rx_byte != shkfd_pkg::HDR1) count_in = '0;
            end
            shkfd_pkg::POS_TYPE: begin
               if (req_rx_byte != shkfd_pkg::HDR_TYPE) count_in = '0;
            end
            shkfd_pkg::FRAME_LAST: begin
               count_in = '0;
            end
            default: begin
               store_wr = 1'b1;
            end
         endcase
      end
   end

   // last report byte comes straight from the port
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         rpt[i*8 +: 8] = report_ff[i];
      end
      rpt[STORE_DEPTH*8 +: 8] = req_rx_byte;
   end

   assign q_push = accept && (pos == shkfd_pkg::FRAME_LAST);
   assign q_item = shkfd_pkg::classify(rpt);
   assign q_time = now_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_time_ff <= '0;
      end else begin
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         report_ff[store_idx] <= req_rx_byte;
      end
   end

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && pos == shkfd_pkg::FRAME_LAST) |=> (count_ff == '0))
      else $error("count not cleared after last frame byte");

   a_gap_bad_header: assert property (@(posedge clock) disable iff (reset)
      (accept && gap_passed && req_rx_byte != shkfd_pkg::HDR0) |=> (count_ff == '0))
      else $error("frame kept after gap with wrong first byte");

endmodule

/* sv/shkfd_queue.sv */
// ----------------------------------------------------------------------------
// shkfd_queue - two-entry report queue
// Decouples frame assembly from event generation.
// ----------------------------------------------------------------------------
module shkfd_queue #(
   parameter int TIME_BITS = shkfd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  shkfd_pkg::rpt_item_type   push_item,
   input  logic [TIME_BITS-1:0]      push_time,
   output logic                      full,
   input  logic                      pop,
   output logic                      pop_valid,
   output shkfd_pkg::rpt_item_type   pop_item,
   output logic [TIME_BITS-1:0]      pop_time
);

   localparam int DEPTH = 2;

   logic [1:0]                 count_ff, count_in;
   logic                       wr_ptr_ff, rd_ptr_ff;
   shkfd_pkg::rpt_item_type    item_mem_ff [DEPTH];
   logic [TIME_BITS-1:0]       time_mem_ff [DEPTH];

   assign full      = (count_ff == 2'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = item_mem_ff[rd_ptr_ff];
   assign pop_time  = time_mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_mem_ff[wr_ptr_ff] <= push_item;
         time_mem_ff[wr_ptr_ff] <= push_time;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue pop while empty");

endmodule

/* sv/shkfd_back.sv */
// ----------------------------------------------------------------------------
// shkfd_back - event generation back end
// Applies the double-ctrl window and registers at most one event per report.
// ----------------------------------------------------------------------------
module shkfd_back #(
   parameter int TIME_BITS = shkfd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  shkfd_pkg::rpt_item_type           q_item,
   input  logic [TIME_BITS-1:0]              q_time,
   output logic                              q_pop,
   input  logic [shkfd_pkg::LIMIT_BITS-1:0]  double_press,
   input  logic                              keyboard_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_source_id,
   output logic [2:0]                        rsp_key_event
);

   logic                        armed_ff, armed_in;
   logic [TIME_BITS-1:0]        last_ctrl_ff, last_ctrl_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        source_ff;
   shkfd_pkg::key_event_type    key_ff;

   logic                        emit;
   shkfd_pkg::key_event_type    key_new;
   logic [TIME_BITS-1:0]        elapsed;
   logic                        passed;

   assign q_pop   = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign elapsed = q_time - last_ctrl_ff;
   assign passed  = elapsed > TIME_BITS'(double_press);

   always_comb begin
      emit         = 1'b0;
      key_new      = q_item.key;
      armed_in     = armed_ff;
      last_ctrl_in = last_ctrl_ff;
      if (q_pop) begin
         case (q_item.cls)
            shkfd_pkg::CLS_CTRL: begin
               last_ctrl_in = q_time;
               if (armed_ff && !passed) begin
                  emit     = 1'b1;
                  key_new  = shkfd_pkg::KEY_DOUBLE_CTRL;
                  armed_in = 1'b0;
               end else begin
                  armed_in = 1'b1;
               end
            end
            shkfd_pkg::CLS_KEY: begin
               emit = 1'b1;
            end
            default: begin
               armed_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= 1'b0;
         last_ctrl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         armed_ff     <= armed_in;
         last_ctrl_ff <= last_ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         source_ff <= keyboard_id;
         key_ff    <= key_new;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_source_id = source_ff;
   assign rsp_key_event = key_ff;

   a_unmatched_disarms: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.cls == shkfd_pkg::CLS_NONE) |=> !armed_ff)
      else $error("unmatched report left ctrl armed");

   a_double_ctrl_emits: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.cls == shkfd_pkg::CLS_CTRL && armed_ff && !passed)
      |=> (rsp_valid_ff && !armed_ff && key_ff == shkfd_pkg::KEY_DOUBLE_CTRL))
      else $error("double ctrl not reported");

endmodule

/* sv/serial_hid_key_frame_decoder_unit.sv */
// ----------------------------------------------------------------------------
// serial_hid_key_frame_decoder_unit - serial HID key frame decoder
// Turns a stream of timestamped serial bytes into navigation key events.
// ----------------------------------------------------------------------------
// The unit takes one serial byte per transfer with its millisecond arrival
// time and assembles frames of 0x57, 0xAB, 0x01 and an 8-byte keyboard
// report; a wrong header byte drops the frame, and a gap longer than
// byte_gap_ms (wrapping subtraction, strictly greater) restarts assembly
// before the byte is taken. Each complete report gives at most one event:
// up, down, left, right, enter, or double ctrl when two ctrl reports fall
// within double_press_ms; a report matching no pattern disarms ctrl. A byte
// is taken every clock cycle while req_stall is low: the front end checks the
// frame and compares the report with all fixed patterns in the cycle of the
// transfer, a two-entry queue holds classified reports, and the back end
// registers the event, which passes a queue entry and the result register.
// req_stall is high while the queue holds two reports; it fills only while
// rsp_stall holds the result register. Registers sit at byte addresses 0x0
// (byte_gap_ms), 0x4 (double_press_ms) and 0x8 (keyboard_id); write them
// only while no frame is in flight.
// ----------------------------------------------------------------------------
module serial_hid_key_frame_decoder_unit #(
   parameter int TIME_BITS = shkfd_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // byte input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   input  logic [31:0]                           req_now_ms,
   // event output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_source_id,
   output logic [2:0]                            rsp_key_event,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [shkfd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [shkfd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [shkfd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [shkfd_pkg::LIMIT_BITS-1:0]  byte_gap_ff;
   logic [shkfd_pkg::LIMIT_BITS-1:0]  double_press_ff;
   logic                              keyboard_id_ff;

   logic                              csr_wr;
   shkfd_pkg::csr_index_type          csr_idx;
   logic [TIME_BITS-1:0]              now_t;

   logic                              q_full;
   logic                              q_push;
   shkfd_pkg::rpt_item_type           q_push_item;
   logic [TIME_BITS-1:0]              q_push_time;
   logic                              q_pop;
   logic                              q_valid;
   shkfd_pkg::rpt_item_type           q_pop_item;
   logic [TIME_BITS-1:0]              q_pop_time;

   // Register port: zero-wait, word addressed; low address bits ignored.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = shkfd_pkg::csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_gap_ff     <= shkfd_pkg::BYTE_GAP_RESET;
         double_press_ff <= shkfd_pkg::DOUBLE_PRESS_RESET;
         keyboard_id_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            shkfd_pkg::CSR_BYTE_GAP:     byte_gap_ff     <= csr_pwdata[15:0];
            shkfd_pkg::CSR_DOUBLE_PRESS: double_press_ff <= csr_pwdata[15:0];
            shkfd_pkg::CSR_KEYBOARD_ID:  keyboard_id_ff  <= csr_pwdata[0];
            default: begin
               // unused address: drop the write
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         shkfd_pkg::CSR_BYTE_GAP:     csr_prdata = 32'(byte_gap_ff);
         shkfd_pkg::CSR_DOUBLE_PRESS: csr_prdata = 32'(double_press_ff);
         shkfd_pkg::CSR_KEYBOARD_ID:  csr_prdata = 32'(keyboard_id_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // Time is kept modulo 2^TIME_BITS; narrow or widen the arrival stamp.
   assign now_t = TIME_BITS'(req_now_ms);

   shkfd_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .now_t       (now_t),
      .byte_gap    (byte_gap_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_push_item),
      .q_time      (q_push_time)
   );

   shkfd_queue #(
      .TIME_BITS (TIME_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .push_time (q_push_time),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_pop_item),
      .pop_time  (q_pop_time)
   );

   shkfd_back #(
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_pop_item),
      .q_time        (q_pop_time),
      .q_pop         (q_pop),
      .double_press  (double_press_ff),
      .keyboard_id   (keyboard_id_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_source_id (rsp_source_id),
      .rsp_key_event (rsp_key_event)
   );

endmodule

/* sim/serial_hid_key_frame_decoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_hid_key_frame_decoder_unit_test - key frame decoder testbench
// Sends timestamped serial bytes into the decoder and checks every key event
// against a cycle-free frame and report predictor. A short scripted set of
// frames comes first, then random frames under several register settings,
// with random idling and stalls on both channels.
// ----------------------------------------------------------------------------
module serial_hid_key_frame_decoder_unit_test;
   import shkfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer at all
   localparam int SETTLE_CYCLES  = 6;      // lets a frame without event finish
   localparam int DRAIN_CYCLES   = 8;
   localparam int SCRIPT_ROWS    = 23;
   localparam int PHASE_BYTES    = 160;

   // report usages and modifier bits
   localparam logic [7:0] USAGE_UP       = 8'h52;
   localparam logic [7:0] USAGE_DOWN     = 8'h51;
   localparam logic [7:0] USAGE_LEFT     = 8'h50;
   localparam logic [7:0] USAGE_RIGHT    = 8'h4F;
   localparam logic [7:0] USAGE_ENTER    = 8'h28;
   localparam logic [7:0] USAGE_KP_ENTER = 8'h58;
   localparam logic [7:0] CTRL_LEFT      = 8'h01;
   localparam logic [7:0] CTRL_RIGHT     = 8'h10;

   localparam logic [23:0] GOOD_HDR = {HDR0, HDR1, HDR_TYPE};

   // byte i of a report sits at bits [8i+7:8i]
   localparam report_type RPT_UP       = {40'd0, USAGE_UP, 16'd0};
   localparam report_type RPT_DOWN     = {40'd0, USAGE_DOWN, 16'd0};
   localparam report_type RPT_LEFT     = {40'd0, USAGE_LEFT, 16'd0};
   localparam report_type RPT_RIGHT    = {40'd0, USAGE_RIGHT, 16'd0};
   localparam report_type RPT_ENTER    = {40'd0, USAGE_ENTER, 16'd0};
   localparam report_type RPT_KP_ENTER = {40'd0, USAGE_KP_ENTER, 16'd0};
   localparam report_type RPT_LCTRL    = {56'd0, CTRL_LEFT};
   localparam report_type RPT_RCTRL    = {56'd0, CTRL_RIGHT};
   localparam report_type RPT_JUNK     = '1;

   typedef struct {
      logic          source_id;
      key_event_type key_event;
   } key_note_type;

   // one scripted frame: header, report, bytes sent, timing, typed outcome
   typedef struct packed {
      logic [23:0]   header;
      report_type    report;
      logic [3:0]    sent;
      logic          abs_start;
      logic [31:0]   lead_ms;
      logic [7:0]    step_ms;
      logic          typed;
      logic          want;
      key_event_type want_key;
   } script_row_type;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // each arrow and enter report straight after reset, first byte at time 0
      '{GOOD_HDR, RPT_UP,       4'd11, 1'b1, 32'd0,   8'd1,   1'b1, 1'b1, KEY_UP},
      '{GOOD_HDR, RPT_DOWN,     4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_DOWN},
      '{GOOD_HDR, RPT_LEFT,     4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_LEFT},
      '{GOOD_HDR, RPT_RIGHT,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_RIGHT},
      '{GOOD_HDR, RPT_ENTER,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_ENTER},
      '{GOOD_HDR, RPT_KP_ENTER, 4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_ENTER},
      // arm on left ctrl, double on right ctrl
      '{GOOD_HDR, RPT_LCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_RCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b1, KEY_DOUBLE_CTRL},
      // arm, then an unknown report disarms, so the next ctrl only arms
      '{GOOD_HDR, RPT_LCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_JUNK,     4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_LCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      // a wrong byte in each header position drops the frame
      '{{HDR0 ^ 8'h01, HDR1, HDR_TYPE}, RPT_UP,
                                4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{{HDR0, HDR1 ^ 8'h07, HDR_TYPE}, RPT_UP,
                                4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{{HDR0, HDR1, HDR_TYPE ^ 8'h03}, RPT_UP,
                                4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      // byte gap one above the limit restarts at every byte; at the limit it holds
      '{GOOD_HDR, RPT_UP,       4'd11, 1'b0, 32'd1,   8'd101, 1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_UP,       4'd11, 1'b0, 32'd100, 8'd100, 1'b1, 1'b1, KEY_UP},
      // double press exactly at the window, then one past it
      '{GOOD_HDR, RPT_LCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_RCTRL,    4'd11, 1'b0, 32'd490, 8'd1,   1'b1, 1'b1, KEY_DOUBLE_CTRL},
      '{GOOD_HDR, RPT_LCTRL,    4'd11, 1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_RCTRL,    4'd11, 1'b0, 32'd491, 8'd1,   1'b1, 1'b0, KEY_UP},
      // time wraps from all ones to zero inside the frame
      '{GOOD_HDR, RPT_UP,       4'd11, 1'b1, 32'hFFFF_FFFA, 8'd1, 1'b1, 1'b1, KEY_UP},
      // a cut-off frame, then a fresh one after a gap
      '{GOOD_HDR, RPT_DOWN,     4'd6,  1'b0, 32'd1,   8'd1,   1'b1, 1'b0, KEY_UP},
      '{GOOD_HDR, RPT_ENTER,    4'd11, 1'b0, 32'd101, 8'd1,   1'b1, 1'b1, KEY_ENTER}
   };

   // ------------------------------------------------------------------------
   // DUT ports, inputs all known from time zero
   // ------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_rx_byte = '0;
   logic [31:0]              req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_source_id;
   logic [2:0]               rsp_key_event;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // ------------------------------------------------------------------------
   // predictor state and register copies
   // ------------------------------------------------------------------------
   logic [15:0]     gap_limit_ms = BYTE_GAP_RESET;
   logic [15:0]     press_window_ms = DOUBLE_PRESS_RESET;
   logic            channel_id = 1'b0;
   logic [31:0]     byte_seen_ms = '0;
   logic [3:0]      frame_pos = POS_HDR0;
   logic [7:0]      report_bytes [REPORT_BYTES];
   logic            ctrl_pending = 1'b0;
   logic [31:0]     ctrl_seen_ms = '0;
   logic            frame_made;      // last byte closed a frame with an event
   key_event_type   frame_key;
   key_note_type    awaited_keys [$];

   logic [31:0]     stamp_ms = '0;   // running arrival time of the stream
   logic            steady = 1'b0;   // no idling once set
   int unsigned     bytes_sent;
   int unsigned     events_checked;
   int unsigned     settings_used;
   int unsigned     mismatches;
   int unsigned     quiet_cycles;
   int unsigned     stall_left;

   serial_hid_key_frame_decoder_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rx_byte   (req_rx_byte),
      .req_now_ms    (req_now_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_source_id (rsp_source_id),
      .rsp_key_event (rsp_key_event),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor: advance the frame state by one accepted byte and queue the
   // key event it gives, if any.
   // ------------------------------------------------------------------------
   task automatic decode_byte(input logic [7:0] rx, input logic [31:0] at_ms);
      logic [3:0]   pos;
      logic [31:0]  since;
      logic         clear_but0;
      logic         clear_but2;
      key_note_type note;
      frame_made = 1'b0;
      frame_key  = KEY_UP;
      // a gap strictly longer than the limit restarts framing before the byte
      since = at_ms - byte_seen_ms;
      if (since > 32'(gap_limit_ms)) frame_pos = POS_HDR0;
      byte_seen_ms = at_ms;
      pos = frame_pos;
      frame_pos = pos + 4'd1;
      case (pos)
         POS_HDR0: if (rx != HDR0) frame_pos = POS_HDR0;
         POS_HDR1: if (rx != HDR1) frame_pos = POS_HDR0;
         POS_TYPE: if (rx != HDR_TYPE) frame_pos = POS_HDR0;
         default: begin
            report_bytes[pos - FRAME_FIRST_DATA] = rx;
            if (pos == FRAME_LAST) begin
               frame_pos  = POS_HDR0;
               clear_but0 = 1'b1;
               clear_but2 = 1'b1;
               for (int k = 0; k < REPORT_BYTES; k++) begin
                  if (k != 0 && report_bytes[k] != 8'd0) clear_but0 = 1'b0;
                  if (k != 2 && report_bytes[k] != 8'd0) clear_but2 = 1'b0;
               end
               if (clear_but0 && (report_bytes[0] == CTRL_LEFT ||
                                  report_bytes[0] == CTRL_RIGHT)) begin
                  // second ctrl inside the window fires, otherwise (re)arm
                  since = at_ms - ctrl_seen_ms;
                  if (ctrl_pending && since <= 32'(press_window_ms)) begin
                     frame_made   = 1'b1;
                     frame_key    = KEY_DOUBLE_CTRL;
                     ctrl_pending = 1'b0;
                  end else begin
                     ctrl_pending = 1'b1;
                  end
                  ctrl_seen_ms = at_ms;
               end else if (clear_but2) begin
                  frame_made = 1'b1;
                  case (report_bytes[2])
                     USAGE_UP:       frame_key = KEY_UP;
                     USAGE_DOWN:     frame_key = KEY_DOWN;
                     USAGE_LEFT:     frame_key = KEY_LEFT;
                     USAGE_RIGHT:    frame_key = KEY_RIGHT;
                     USAGE_ENTER,
                     USAGE_KP_ENTER: frame_key = KEY_ENTER;
                     default: begin
                        frame_made   = 1'b0;
                        ctrl_pending = 1'b0;
                     end
                  endcase
               end else begin
                  ctrl_pending = 1'b0;
               end
               if (frame_made) begin
                  note.source_id = channel_id;
                  note.key_event = frame_key;
                  awaited_keys.push_back(note);
               end
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Byte channel: hold the payload until the transfer, idle in bursts
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] rx, input logic [31:0] at_ms);
      int unsigned hold;
      if (!steady && $urandom_range(0, 7) == 0) begin
         hold = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      req_now_ms  <= at_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(rx, at_ms);
      bytes_sent++;
   endtask

   // Send the first count bytes of a frame; the byte at position cut_at
   // (if non-zero) comes cut_ms after its predecessor instead of step_ms.
   task automatic send_frame(input logic [23:0] hdr, input report_type rpt,
                             input int unsigned count, input int unsigned step_ms,
                             input int unsigned cut_at, input int unsigned cut_ms);
      logic [7:0] rx;
      for (int k = 0; k < count; k++) begin
         if (k != 0) stamp_ms += (k == cut_at) ? cut_ms : step_ms;
         rx = (k < 3) ? hdr[8*(2-k) +: 8] : rpt[8*(k-3) +: 8];
         push_byte(rx, stamp_ms);
      end
   endtask

   // Close any half-built frame, then hold the sender until every awaited
   // event has arrived and the pipeline has drained.
   task automatic wait_idle();
      while (frame_pos != POS_HDR0) push_byte(8'h00, stamp_ms);
      req_valid <= 1'b0;
      while (awaited_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Register port: write, read back, mirror into the predictor
   // ------------------------------------------------------------------------
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // write taken at this edge; set up the read of the same register
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== value) begin
         $error("%s readback: expected %0d, got %0d", idx.name(), value, readback);
         mismatches++;
      end
      case (idx)
         CSR_BYTE_GAP:     gap_limit_ms    = value[15:0];
         CSR_DOUBLE_PRESS: press_window_ms = value[15:0];
         CSR_KEYBOARD_ID:  channel_id      = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] gap_ms, input logic [15:0] press_ms,
                                input logic id);
      write_reg(CSR_BYTE_GAP, {16'd0, gap_ms});
      write_reg(CSR_DOUBLE_PRESS, {16'd0, press_ms});
      write_reg(CSR_KEYBOARD_ID, {31'd0, id});
      settings_used++;
   endtask

   // ------------------------------------------------------------------------
   // Random frames: mostly well-formed with random reports and timing,
   // the rest broken headers, cut-off frames, gaps inside a frame and noise.
   // ------------------------------------------------------------------------
   task automatic run_phase(input int unsigned budget, input logic calm_tail);
      int unsigned done;
      int unsigned pick;
      int unsigned shape;
      int unsigned step;
      int unsigned lead;
      int unsigned aim;
      int unsigned count;
      int unsigned cut;
      logic [23:0] hdr;
      report_type  rpt;
      done = 0;
      while (done < budget) begin
         if (calm_tail && done >= budget / 2) steady = 1'b1;
         step = $urandom_range(0, (gap_limit_ms < 3) ? gap_limit_ms : 3);
         if ($urandom_range(0, 19) == 0) stamp_ms = $urandom();

         shape = $urandom_range(0, 99);
         case ((shape < 25) ? $urandom_range(0, 1) : $urandom_range(2, 7))
            0:       rpt = RPT_LCTRL;
            1:       rpt = RPT_RCTRL;
            2:       rpt = RPT_UP;
            3:       rpt = RPT_DOWN;
            4:       rpt = RPT_LEFT;
            5:       rpt = RPT_RIGHT;
            6:       rpt = RPT_ENTER;
            default: rpt = RPT_KP_ENTER;
         endcase
         if (shape >= 85) rpt = {$urandom(), $urandom()};
         else if (shape >= 70) rpt ^= report_type'(1) << $urandom_range(0, 63);

         // place ctrl reports around the double-press window edge
         lead = $urandom_range(0, (gap_limit_ms < 20) ? gap_limit_ms : 20);
         if (rpt == RPT_LCTRL || rpt == RPT_RCTRL) begin
            aim = (press_window_ms > 10 * step) ? press_window_ms - 10 * step : 0;
            case ($urandom_range(0, 2))
               0: ;
               1: lead = (aim == 0) ? $urandom_range(0, 1) : aim - 1 + $urandom_range(0, 2);
               default: lead = $urandom_range(0, 2 * press_window_ms + 10);
            endcase
         end
         stamp_ms += lead;

         hdr  = GOOD_HDR;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            count = 11;
            send_frame(hdr, rpt, count, step, 0, 0);
         end else if (pick < 80) begin
            cut = $urandom_range(0, 2);
            hdr[8*cut +: 8] = hdr[8*cut +: 8] ^ 8'($urandom_range(1, 255));
            count = 11;
            send_frame(hdr, rpt, count, step, 0, 0);
         end else if (pick < 88) begin
            count = $urandom_range(1, 10);
            send_frame(hdr, rpt, count, step, 0, 0);
         end else if (pick < 95) begin
            count = 11;
            send_frame(hdr, rpt, count, step, $urandom_range(1, 10),
                       gap_limit_ms + 1 + $urandom_range(0, 3));
         end else begin
            // noise does not count towards the phase
            count = 0;
            repeat ($urandom_range(1, 5)) begin
               stamp_ms += $urandom_range(0, gap_limit_ms + 2);
               push_byte(8'($urandom_range(0, 255)), stamp_ms);
            end
         end
         done += count;
      end
   endtask

   // ------------------------------------------------------------------------
   // Event channel: stall in bursts, with rsp_stall dropping low between bursts
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && !steady && !rsp_stall && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each event transfer with the oldest awaited event.
   always @(posedge clock) begin
      key_note_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_keys.size() == 0) begin
            $error("unexpected event: source_id %0d key_event %0d",
                   rsp_source_id, rsp_key_event);
            mismatches++;
         end else begin
            want = awaited_keys.pop_front();
            if (rsp_source_id !== want.source_id) begin
               $error("source_id: expected %0d, got %0d", want.source_id, rsp_source_id);
               mismatches++;
            end
            if (rsp_key_event !== want.key_event) begin
               $error("key_event: expected %0d, got %0d", want.key_event, rsp_key_event);
               mismatches++;
            end
            events_checked++;
         end
      end
   end

   // Drop out if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin
      script_row_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // scripted frames under the reset register values
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row = SCRIPT[r];
         if (row.abs_start) stamp_ms = row.lead_ms;
         else stamp_ms += row.lead_ms;
         send_frame(row.header, row.report, row.sent, row.step_ms, 0, 0);
         if (row.typed && (frame_made != row.want ||
                           (row.want && frame_key != row.want_key))) begin
            $error("row %0d key_event: expected %0d/%0d, got %0d/%0d",
                   r, row.want, row.want_key, frame_made, frame_key);
            mismatches++;
         end
      end

      // random phases, registers changed only with the decoder idle
      wait_idle();
      set_registers(16'd0, 16'd0, 1'b1);
      run_phase(PHASE_BYTES, 1'b0);
      wait_idle();
      set_registers(16'hFFFF, 16'hFFFF, 1'b0);
      run_phase(PHASE_BYTES, 1'b0);
      wait_idle();
      set_registers(16'($urandom_range(1, 300)), 16'($urandom_range(0, 1500)), 1'b1);
      run_phase(PHASE_BYTES, 1'b0);
      wait_idle();
      set_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
      run_phase(PHASE_BYTES, 1'b1);

      // release the channel and drain
      req_valid <= 1'b0;
      while (awaited_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d byte transfers and %0d key events over %0d settings,",
               bytes_sent, events_checked, settings_used + 1);
      $display("with broken headers, byte gaps, ctrl window edges and time wrap.");
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
